/* hdl/ssui_pkg.sv */
// Shared types and constants for the sorted set union / intersection block.
// No dependencies; imported by ssui_ctrl, ssui_dp and the top level.
package ssui_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   // request operation codes
   localparam logic [1:0] OP_INS_A = 2'd0;
   localparam logic [1:0] OP_INS_B = 2'd1;
   localparam logic [1:0] OP_EMIT  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // response status codes
   localparam logic [1:0] RSP_OK      = 2'd0;
   localparam logic [1:0] RSP_FULL    = 2'd1;
   localparam logic [1:0] RSP_EMPTY   = 2'd2;
   localparam logic [1:0] RSP_CLEARED = 2'd3;

   // response set kind
   localparam logic KIND_UNION = 1'b0;
   localparam logic KIND_ISX   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_BEGIN,
      S_INS_SHIFT,
      S_INS_PLACE,
      S_UNI_STEP,
      S_ISX_STEP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       ins_begin;
      logic       ins_shift;
      logic       ins_place;
      logic       clear;
      logic       rsp_one;
      logic [1:0] rsp_code;
      logic       uni_start;
      logic       uni_step;
      logic       isx_start;
      logic       isx_step;
      logic       flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sel_full;
      logic sel_empty;
      logic ins_stop;
      logic idx_one;
      logic uni_done;
      logic isx_done;
   } stat_type;

endpackage

/* hdl/ssui_ctrl.sv */
// Controller state machine for the sorted set union / intersection block.
// Depends on ssui_pkg; drives ssui_dp through cmd_type, reads stat_type.
module ssui_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_operation,
   input  ssui_pkg::stat_type stat,
   output ssui_pkg::cmd_type  cmd,
   output logic              busy
);
   import ssui_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  OP_INS_A, OP_INS_B: begin
                     state_in = S_INS_BEGIN;
                  end
                  OP_EMIT: begin
                     cmd.uni_start = 1'b1;
                     state_in      = S_UNI_STEP;
                  end
                  OP_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.rsp_one  = 1'b1;
                     cmd.rsp_code = RSP_CLEARED;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_INS_BEGIN: begin
            cmd.ins_begin = 1'b1;
            if (stat.sel_full) begin
               cmd.rsp_one  = 1'b1;
               cmd.rsp_code = RSP_FULL;
               state_in     = S_IDLE;
            end else if (stat.sel_empty) begin
               state_in = S_INS_PLACE;
            end else begin
               state_in = S_INS_SHIFT;
            end
         end
         S_INS_SHIFT: begin
            if (stat.ins_stop) begin
               cmd.ins_place = 1'b1;
               cmd.rsp_one   = 1'b1;
               cmd.rsp_code  = RSP_OK;
               state_in      = S_IDLE;
            end else begin
               cmd.ins_shift = 1'b1;
               if (stat.idx_one) begin
                  state_in = S_INS_PLACE;
               end
            end
         end
         S_INS_PLACE: begin
            cmd.ins_place = 1'b1;
            cmd.rsp_one   = 1'b1;
            cmd.rsp_code  = RSP_OK;
            state_in      = S_IDLE;
         end
         S_UNI_STEP: begin
            if (stat.uni_done) begin
               cmd.isx_start = 1'b1;
               state_in      = S_ISX_STEP;
            end else begin
               cmd.uni_step = 1'b1;
            end
         end
         S_ISX_STEP: begin
            if (stat.isx_done) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.isx_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* hdl/ssui_dp.sv */
// Datapath: list memories, counts, merge indices, pending result and response regs.
// Depends on ssui_pkg; commanded by ssui_ctrl.
module ssui_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  ssui_pkg::cmd_type          cmd,
   input  logic [1:0]                 req_operation,
   input  logic signed [ssui_pkg::VAL_W-1:0] req_value,
   output ssui_pkg::stat_type         stat,
   output logic                       rsp_strobe,
   output logic signed [ssui_pkg::VAL_W-1:0] rsp_value_res,
   output logic                       rsp_set_kind,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_last
);
   import ssui_pkg::*;

   // list memories, read data registered
   logic signed [VAL_W-1:0] mem_a [LIST_DEPTH];
   logic signed [VAL_W-1:0] mem_b [LIST_DEPTH];
   logic signed [VAL_W-1:0] rd_a_ff, rd_b_ff;

   logic [1:0]              op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]        cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        ia_ff, ia_in, ib_ff, ib_in;
   logic signed [VAL_W-1:0] prev_ff, prev_in;
   logic                    have_prev_ff, have_prev_in;
   logic signed [VAL_W-1:0] pend_val_ff, pend_val_in;
   logic                    pend_kind_ff, pend_kind_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic signed [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    wr_a_en, wr_b_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [VAL_W-1:0] wr_data;
   logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b;
   logic [CNT_W-1:0]        idx_m1;

   logic                    sel_b;
   logic [CNT_W-1:0]        cnt_sel;
   logic signed [VAL_W-1:0] rd_sel;
   logic                    a_ok, b_ok;
   logic signed [VAL_W-1:0] uni_v;
   logic                    push;
   logic signed [VAL_W-1:0] push_val;
   logic                    push_kind;

   assign sel_b   = op_ff[0];
   assign cnt_sel = sel_b ? cnt_b_ff : cnt_a_ff;
   assign rd_sel  = sel_b ? rd_b_ff : rd_a_ff;
   assign a_ok    = (ia_ff < cnt_a_ff);
   assign b_ok    = (ib_ff < cnt_b_ff);

   // status to controller
   always_comb begin
      stat.sel_full  = (cnt_sel == CNT_W'(LIST_DEPTH));
      stat.sel_empty = (cnt_sel == '0);
      stat.ins_stop  = (val_ff > rd_sel);
      stat.idx_one   = (idx_ff == CNT_W'(1));
      stat.uni_done  = !a_ok && !b_ok;
      stat.isx_done  = !(a_ok && b_ok);
   end

   // union merge pick
   always_comb begin
      if (a_ok && b_ok) begin
         uni_v = (rd_a_ff > rd_b_ff) ? rd_b_ff : rd_a_ff;
      end else if (a_ok) begin
         uni_v = rd_a_ff;
      end else begin
         uni_v = rd_b_ff;
      end
   end

   // next-state logic for all datapath registers
   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      idx_in        = idx_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      pend_val_in   = pend_val_ff;
      pend_kind_in  = pend_kind_ff;
      pend_vld_in   = pend_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_val_in    = rsp_val_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_a_en       = 1'b0;
      wr_b_en       = 1'b0;
      wr_addr       = idx_ff[ADDR_W-1:0];
      wr_data       = val_ff;
      push          = 1'b0;
      push_val      = uni_v;
      push_kind     = KIND_UNION;

      if (cmd.capture) begin
         op_in  = req_operation;
         val_in = req_value;
      end

      // insert: walk down from the top, moving entries not below the new value up one slot
      if (cmd.ins_begin) begin
         idx_in = cnt_sel;
      end
      if (cmd.ins_shift) begin
         wr_data = rd_sel;
         wr_a_en = !sel_b;
         wr_b_en = sel_b;
         idx_in  = idx_ff - CNT_W'(1);
      end
      if (cmd.ins_place) begin
         wr_data = val_ff;
         wr_a_en = !sel_b;
         wr_b_en = sel_b;
         if (sel_b) begin
            cnt_b_in = cnt_b_ff + CNT_W'(1);
         end else begin
            cnt_a_in = cnt_a_ff + CNT_W'(1);
         end
      end

      if (cmd.clear) begin
         cnt_a_in = '0;
         cnt_b_in = '0;
      end

      // single response for insert, full and clear
      if (cmd.rsp_one) begin
         rsp_strobe_in = 1'b1;
         rsp_val_in    = (cmd.rsp_code == RSP_CLEARED) ? '0 : val_ff;
         rsp_kind_in   = KIND_UNION;
         rsp_status_in = cmd.rsp_code;
         rsp_last_in   = 1'b1;
      end

      if (cmd.uni_start || cmd.isx_start) begin
         ia_in = '0;
         ib_in = '0;
      end
      if (cmd.uni_start) begin
         have_prev_in = 1'b0;
         pend_vld_in  = 1'b0;
      end

      // union step: take the smaller head, both on a tie
      if (cmd.uni_step) begin
         if (a_ok && b_ok) begin
            if (rd_a_ff == rd_b_ff) begin
               ia_in = ia_ff + CNT_W'(1);
               ib_in = ib_ff + CNT_W'(1);
            end else if (rd_a_ff > rd_b_ff) begin
               ib_in = ib_ff + CNT_W'(1);
            end else begin
               ia_in = ia_ff + CNT_W'(1);
            end
         end else if (a_ok) begin
            ia_in = ia_ff + CNT_W'(1);
         end else begin
            ib_in = ib_ff + CNT_W'(1);
         end
         if (!(have_prev_ff && (uni_v == prev_ff))) begin
            have_prev_in = 1'b1;
            prev_in      = uni_v;
            push         = 1'b1;
         end
      end

      // intersection step: advance the smaller head, emit on a match
      if (cmd.isx_step) begin
         push_kind = KIND_ISX;
         push_val  = rd_a_ff;
         if (rd_a_ff == rd_b_ff) begin
            push  = 1'b1;
            ia_in = ia_ff + CNT_W'(1);
            ib_in = ib_ff + CNT_W'(1);
         end else if (rd_a_ff > rd_b_ff) begin
            ib_in = ib_ff + CNT_W'(1);
         end else begin
            ia_in = ia_ff + CNT_W'(1);
         end
      end

      // one-deep hold so the final emitted item can carry last
      if (push) begin
         if (pend_vld_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_val_in    = pend_val_ff;
            rsp_kind_in   = pend_kind_ff;
            rsp_status_in = RSP_OK;
            rsp_last_in   = 1'b0;
         end
         pend_val_in  = push_val;
         pend_kind_in = push_kind;
         pend_vld_in  = 1'b1;
      end

      if (cmd.flush) begin
         rsp_strobe_in = 1'b1;
         rsp_last_in   = 1'b1;
         if (pend_vld_ff) begin
            rsp_val_in    = pend_val_ff;
            rsp_kind_in   = pend_kind_ff;
            rsp_status_in = RSP_OK;
         end else begin
            rsp_val_in    = '0;
            rsp_kind_in   = KIND_UNION;
            rsp_status_in = RSP_EMPTY;
         end
         pend_vld_in = 1'b0;
      end
   end

   // read addresses follow the next index so the registered read data lines up with it
   assign idx_m1 = idx_in - CNT_W'(1);
   always_comb begin
      if (cmd.ins_begin || cmd.ins_shift) begin
         rd_addr_a = idx_m1[ADDR_W-1:0];
         rd_addr_b = idx_m1[ADDR_W-1:0];
      end else begin
         rd_addr_a = ia_in[ADDR_W-1:0];
         rd_addr_b = ib_in[ADDR_W-1:0];
      end
   end

   // list memories
   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (wr_b_en) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_addr_a];
      rd_b_ff <= mem_b[rd_addr_b];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         have_prev_ff  <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         have_prev_ff  <= have_prev_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      prev_ff       <= prev_in;
      pend_val_ff   <= pend_val_in;
      pend_kind_ff  <= pend_kind_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value_res = rsp_val_ff;
   assign rsp_set_kind  = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNT_W'(LIST_DEPTH)) && (cnt_b_ff <= CNT_W'(LIST_DEPTH)))
      else $error("list count above depth");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff != RSP_OK)) |-> rsp_last_ff)
      else $error("non-ok response without last");

   a_place_a: assert property (@(posedge clock) disable iff (reset)
      (cmd.ins_place && !sel_b && !cmd.clear) |=>
      (cnt_a_ff == $past(cnt_a_ff) + CNT_W'(1)))
      else $error("insert into A did not bump count");

   a_wr_insert: assert property (@(posedge clock) disable iff (reset)
      (wr_a_en || wr_b_en) |-> (cmd.ins_shift || cmd.ins_place))
      else $error("list write outside insert");

endmodule

/* hdl/sorted_set_union_intersection.sv */
// Top level of the sorted set union / intersection block.
// Depends on ssui_pkg, ssui_ctrl and ssui_dp.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------------
//   request   | start && !busy     | req_operation, req_value
//   response  | rsp_strobe (1 clk) | rsp_value_res, rsp_set_kind, rsp_status,
//             |                    | rsp_last
//
// An insert walks down the list, shifting each entry not below the new value up one
// slot, each step waiting on the registered list read; an insert into a full list is
// refused before any shift. Clear completes without leaving idle; emit runs one merge step per
// cycle, union then intersection. Reset empties both lists at once; no clearing pass.
// Responses are registered and cannot be stalled.
module sorted_set_union_intersection (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic signed [ssui_pkg::VAL_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic signed [ssui_pkg::VAL_W-1:0] rsp_value_res,
   output logic                              rsp_set_kind,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last
);
   import ssui_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ssui_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   ssui_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_operation (req_operation),
      .req_value     (req_value),
      .stat          (stat),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_set_kind  (rsp_set_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

/* sim/set_merge_checker.sv */
// Response checker for sorted_set_union_intersection: keeps its own copy of both lists,
// predicts every response from the accepted requests and compares them. Uses ssui_pkg.
module set_merge_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic signed [ssui_pkg::VAL_W-1:0] req_value,
   input  logic                              rsp_strobe,
   input  logic signed [ssui_pkg::VAL_W-1:0] rsp_value_res,
   input  logic                              rsp_set_kind,
   input  logic [1:0]                        rsp_status,
   input  logic                              rsp_last,
   output int                                errors,
   output int                                pending
);
   import ssui_pkg::*;

   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    kind;
      logic [1:0]              status;
      logic                    last;
   } set_rsp_type;

   // shadow of both lists: index 0 is list A, index 1 is list B
   logic signed [VAL_W-1:0] lists [2][LIST_DEPTH];
   int                      counts [2];
   set_rsp_type             expected_rsps [$];
   int                      err_count = 0;

   function automatic set_rsp_type make_rsp(logic signed [VAL_W-1:0] value, logic kind,
                                            logic [1:0] status);
      set_rsp_type r;
      r.value  = value;
      r.kind   = kind;
      r.status = status;
      r.last   = 1'b0;
      return r;
   endfunction

   // ascending insert, new value goes ahead of equal ones
   task automatic sorted_place(int sel, logic signed [VAL_W-1:0] v, output logic ok);
      int pos = 0;
      ok = (counts[sel] < LIST_DEPTH);
      if (ok) begin
         while (pos < counts[sel] && v > lists[sel][pos]) pos++;
         for (int i = counts[sel]; i > pos; i--) lists[sel][i] = lists[sel][i-1];
         lists[sel][pos] = v;
         counts[sel]++;
      end
   endtask

   // union with repeats dropped, then one intersection item per matched pair
   task automatic merge_emit();
      set_rsp_type             batch [$];
      int                      i;
      int                      j;
      logic                    have_prev;
      logic signed [VAL_W-1:0] prev;
      logic signed [VAL_W-1:0] v;
      i = 0;
      j = 0;
      have_prev = 1'b0;
      prev = '0;
      while (i < counts[0] || j < counts[1]) begin
         if (i < counts[0] && j < counts[1]) begin
            if (lists[0][i] == lists[1][j]) begin
               v = lists[0][i];
               i++;
               j++;
            end else if (lists[0][i] > lists[1][j]) begin
               v = lists[1][j];
               j++;
            end else begin
               v = lists[0][i];
               i++;
            end
         end else if (i < counts[0]) begin
            v = lists[0][i];
            i++;
         end else begin
            v = lists[1][j];
            j++;
         end
         if (!(have_prev && v == prev)) begin
            batch.push_back(make_rsp(v, KIND_UNION, RSP_OK));
            have_prev = 1'b1;
            prev = v;
         end
      end
      i = 0;
      j = 0;
      while (i < counts[0] && j < counts[1]) begin
         if (lists[0][i] == lists[1][j]) begin
            batch.push_back(make_rsp(lists[0][i], KIND_ISX, RSP_OK));
            i++;
            j++;
         end else if (lists[0][i] > lists[1][j]) begin
            j++;
         end else begin
            i++;
         end
      end
      // both lists empty
      if (batch.size() == 0) batch.push_back(make_rsp('0, KIND_UNION, RSP_EMPTY));
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) expected_rsps.push_back(batch[k]);
   endtask

   task automatic predict_request(logic [1:0] op, logic signed [VAL_W-1:0] v);
      set_rsp_type r;
      logic        ok;
      case (op)
         OP_INS_A, OP_INS_B: begin
            sorted_place((op == OP_INS_B) ? 1 : 0, v, ok);
            r = make_rsp(v, KIND_UNION, ok ? RSP_OK : RSP_FULL);
            r.last = 1'b1;
            expected_rsps.push_back(r);
         end
         OP_CLEAR: begin
            counts[0] = 0;
            counts[1] = 0;
            r = make_rsp('0, KIND_UNION, RSP_CLEARED);
            r.last = 1'b1;
            expected_rsps.push_back(r);
         end
         OP_EMIT: begin
            merge_emit();
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(string name, logic [VAL_W-1:0] exp, logic [VAL_W-1:0] act);
      if (act !== exp) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         err_count++;
      end
   endtask

   // requests and responses are both taken at the clock edge
   always @(posedge clock) begin
      set_rsp_type e;
      if (reset) begin
         counts[0] = 0;
         counts[1] = 0;
         expected_rsps.delete();
      end else begin
         if (start && !busy) predict_request(req_operation, req_value);
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("response with none expected: value %0h status %0d",
                      rsp_value_res, rsp_status);
               err_count++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("value_res", e.value, rsp_value_res);
               check_field("set_kind", VAL_W'(e.kind), VAL_W'(rsp_set_kind));
               check_field("status", VAL_W'(e.status), VAL_W'(rsp_status));
               check_field("last", VAL_W'(e.last), VAL_W'(rsp_last));
            end
         end
      end
      errors  <= err_count;
      pending <= expected_rsps.size();
   end

endmodule

/* sim/tb.sv */
// Testbench top for sorted_set_union_intersection: directed and random request streams.
// Depends on ssui_pkg, the block and set_merge_checker.
module tb;
   import ssui_pkg::*;

   localparam int RANDOM_ITEMS = 470;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    start         = 1'b0;
   logic [1:0]              req_operation = OP_INS_A;
   logic signed [VAL_W-1:0] req_value     = '0;
   logic                    busy;
   logic                    rsp_strobe;
   logic signed [VAL_W-1:0] rsp_value_res;
   logic                    rsp_set_kind;
   logic [1:0]              rsp_status;
   logic                    rsp_last;
   int                      errors;
   int                      pending;
   int                      sent   = 0;
   int                      cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sorted_set_union_intersection dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_set_kind  (rsp_set_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   set_merge_checker merge_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_set_kind  (rsp_set_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .errors        (errors),
      .pending       (pending)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one request; random gaps except in a quiet stretch of the run
   task automatic send(logic [1:0] op, logic signed [VAL_W-1:0] v);
      while (!(sent >= 150 && sent < 260) && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // mostly values near a base so lists share and repeat entries
   function automatic logic signed [VAL_W-1:0] pick_value(logic signed [VAL_W-1:0] base);
      int unsigned r = $urandom_range(0, 99);
      if (r < 55) return base + $urandom_range(0, 11);
      if (r < 65) return 32'h8000_0000 + $urandom_range(0, 3);
      if (r < 75) return 32'h7fff_ffff - $urandom_range(0, 3);
      return $urandom();
   endfunction

   // fill both lists, sometimes past full, then emit and usually clear
   task automatic random_round();
      logic signed [VAL_W-1:0] base;
      int                      na;
      int                      nb;
      base = $urandom();
      na = ($urandom_range(0, 99) < 15) ? LIST_DEPTH + 2 : $urandom_range(0, LIST_DEPTH);
      nb = ($urandom_range(0, 99) < 15) ? LIST_DEPTH + 2 : $urandom_range(0, LIST_DEPTH);
      while (na > 0 || nb > 0) begin
         if ($urandom_range(0, 99) < 8) send(2'($urandom_range(0, 3)), $urandom());
         if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 1)) begin
            send(OP_INS_A, pick_value(base));
            na--;
         end else begin
            send(OP_INS_B, pick_value(base));
            nb--;
         end
      end
      send(OP_EMIT, $urandom());
      if ($urandom_range(0, 99) < 75) send(OP_CLEAR, $urandom());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty emit, extremes, duplicates, shared values
      send(OP_EMIT, 32'h7fff_ffff);
      send(OP_INS_A, 32'h8000_0000);
      send(OP_INS_A, 32'h7fff_ffff);
      send(OP_INS_B, 32'h7fff_ffff);
      send(OP_INS_B, 32'h0000_0000);
      send(OP_INS_A, 32'h0000_0000);
      send(OP_INS_A, 32'h0000_0000);
      send(OP_INS_B, 32'hffff_ffff);
      send(OP_EMIT, 32'h0000_0000);
      // fill list A, then one insert past full
      repeat (LIST_DEPTH - 4) send(OP_INS_A, $urandom_range(0, 20) - 10);
      send(OP_INS_A, 32'h1234_5678);
      send(OP_EMIT, 32'hffff_ffff);
      send(OP_CLEAR, 32'h5555_aaaa);
      send(OP_EMIT, 32'haaaa_5555);

      while (sent < RANDOM_ITEMS - 10) random_round();
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
